[hw/rtl/mjt_pkg.sv]
// Shared types, constants and step tables for the min-jerk trajectory step unit.
`default_nettype none

package mjt_pkg;

   localparam int GUARD_BITS = 20;
   localparam logic [15:0] RATE_RESET = 16'd1000;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);

   // Classified transaction handed from the front end to the back end.
   typedef struct packed {
      logic [31:0] pos;
      logic [31:0] vel;
      logic [31:0] acc;
      logic [32:0] dpos;      // goal_pos - pos, signed
      logic [31:0] goal_vel;
      logic [31:0] goal_acc;
      logic [15:0] ticks;
      logic [15:0] rate;
      logic        last;
      logic        ok;        // ticks and rate both nonzero
   } job_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_DIV,
      ST_ACC,
      ST_SUM,
      ST_MUL1,
      ST_MUL2,
      ST_OUT
   } state_type;

   // One entry per divide chain of the quintic fit.
   typedef enum logic [3:0] {
      STEP_V0,
      STEP_V1,
      STEP_A0,
      STEP_A1,
      STEP_Q3A,
      STEP_Q3B,
      STEP_Q3C,
      STEP_Q4A,
      STEP_Q4B,
      STEP_Q4C,
      STEP_Q5A,
      STEP_Q5B,
      STEP_Q5C
   } step_type;

   // Number of chained truncating divides for a step.
   function automatic logic [2:0] step_count(input step_type s);
      logic [2:0] c;
      unique case (s)
         STEP_V0, STEP_V1, STEP_Q3C:           c = 3'd1;
         STEP_A0, STEP_A1, STEP_Q3B, STEP_Q4C: c = 3'd2;
         STEP_Q3A, STEP_Q4B, STEP_Q5C:         c = 3'd3;
         STEP_Q4A, STEP_Q5B:                   c = 3'd4;
         STEP_Q5A:                             c = 3'd5;
         default:                              c = 3'd1;
      endcase
      return c;
   endfunction

   // Divisor is the servo rate (else the tick count).
   function automatic logic step_by_rate(input step_type s);
      return (s == STEP_V0) || (s == STEP_V1) || (s == STEP_A0) || (s == STEP_A1);
   endfunction

endpackage

`default_nettype wire

[hw/rtl/min_jerk_trajectory_step_unit.sv]
// Top level of the min-jerk quintic trajectory step unit.
//
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/req_stall | pos, vel, acc, goal_*, ticks_to_go, last_joint
//  rsp     | out       | rsp_valid/rsp_stall | next_pos/vel/acc, step_ok, last_out
//  csr     | in        | csr_we              | csr_wdata = servo_rate
//
// A computed transaction runs 33 chained divides on the shared radix-16 divider
//   in the back end, plus load/accumulate and the sum, two scaling multiplies
//   and the output slot.
// A transaction with zero ticks or zero rate skips the fit and goes straight to the output slot.
// The front end queues up to 4 transactions, so req is taken while the back end works, until the queue is full.
// Synchronous active-high reset; servo_rate resets to 1000.
// rsp is a registered slot: a finished transaction holds while rsp_stall is high.
`default_nettype none

module min_jerk_trajectory_step_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [15:0] csr_wdata,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_pos,
   input  wire logic [31:0] req_vel,
   input  wire logic [31:0] req_acc,
   input  wire logic [31:0] req_goal_pos,
   input  wire logic [31:0] req_goal_vel,
   input  wire logic [31:0] req_goal_acc,
   input  wire logic [15:0] req_ticks_to_go,
   input  wire logic        req_last_joint,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_next_pos,
   output logic [31:0]      rsp_next_vel,
   output logic [31:0]      rsp_next_acc,
   output logic             rsp_step_ok,
   output logic             rsp_last_out
);

   // Queue head between front and back.
   mjt_pkg::job_type job;
   logic job_valid, job_pop;

   mjt_front u_front (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pos         (req_pos),
      .req_vel         (req_vel),
      .req_acc         (req_acc),
      .req_goal_pos    (req_goal_pos),
      .req_goal_vel    (req_goal_vel),
      .req_goal_acc    (req_goal_acc),
      .req_ticks_to_go (req_ticks_to_go),
      .req_last_joint  (req_last_joint),
      .job_valid       (job_valid),
      .job             (job),
      .job_pop         (job_pop)
   );

   // Back end walks the fit one divide chain at a time.
   mjt_back u_back (
      .clock        (clock),
      .reset        (reset),
      .job_valid    (job_valid),
      .job          (job),
      .job_pop      (job_pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_next_pos (rsp_next_pos),
      .rsp_next_vel (rsp_next_vel),
      .rsp_next_acc (rsp_next_acc),
      .rsp_step_ok  (rsp_step_ok),
      .rsp_last_out (rsp_last_out)
   );

endmodule

`default_nettype wire

[hw/rtl/mjt_front.sv]
// Front end: rate register, classification and the job queue.
`default_nettype none

module mjt_front (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            csr_we,
   input  wire logic [15:0]     csr_wdata,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire logic [31:0]     req_pos,
   input  wire logic [31:0]     req_vel,
   input  wire logic [31:0]     req_acc,
   input  wire logic [31:0]     req_goal_pos,
   input  wire logic [31:0]     req_goal_vel,
   input  wire logic [31:0]     req_goal_acc,
   input  wire logic [15:0]     req_ticks_to_go,
   input  wire logic            req_last_joint,
   output logic                 job_valid,
   output mjt_pkg::job_type     job,
   input  wire logic            job_pop
);

   logic [15:0] rate_ff;
   mjt_pkg::job_type queue_ff [mjt_pkg::QUEUE_DEPTH];
   logic [mjt_pkg::QPTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [mjt_pkg::QPTR_BITS:0]   count_ff;
   mjt_pkg::job_type new_job;
   logic push, pop;

   always_comb begin
      new_job.pos      = req_pos;
      new_job.vel      = req_vel;
      new_job.acc      = req_acc;
      new_job.dpos     = {req_goal_pos[31], req_goal_pos} - {req_pos[31], req_pos};
      new_job.goal_vel = req_goal_vel;
      new_job.goal_acc = req_goal_acc;
      new_job.ticks    = req_ticks_to_go;
      new_job.rate     = rate_ff;
      new_job.last     = req_last_joint;
      new_job.ok       = (req_ticks_to_go != 16'd0) && (rate_ff != 16'd0);
   end

   assign req_stall = (count_ff == (mjt_pkg::QPTR_BITS+1)'(mjt_pkg::QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign job_valid = (count_ff != '0);
   assign pop       = job_pop && job_valid;
   assign job       = queue_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff   <= mjt_pkg::RATE_RESET;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (csr_we) rate_ff <= csr_wdata;
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (push && !pop) count_ff <= count_ff + 1'b1;
         else if (pop && !push) count_ff <= count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) queue_ff[wr_ptr_ff] <= new_job;
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (mjt_pkg::QPTR_BITS+1)'(mjt_pkg::QUEUE_DEPTH))
      else $error("queue count overflow");
   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers out of step");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |=> (count_ff <= 1))
      else $error("queue count jumped from empty");
`endif

endmodule

`default_nettype wire

[hw/rtl/mjt_back.sv]
// Back end: sequenced fit using a shared radix-16 divider, scaling and output register.
`default_nettype none

module mjt_back (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            job_valid,
   input  wire mjt_pkg::job_type job,
   output logic                 job_pop,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output logic [31:0]          rsp_next_pos,
   output logic [31:0]          rsp_next_vel,
   output logic [31:0]          rsp_next_acc,
   output logic                 rsp_step_ok,
   output logic                 rsp_last_out
);

   localparam logic signed [63:0] SAT = 64'sh7FFF_FFFF_FFFF_FFFF;

   mjt_pkg::state_type state_ff, state_in;
   mjt_pkg::step_type  step_ff;
   mjt_pkg::job_type   job_ff;

   logic signed [63:0] v0_ff, v1_ff, a0_ff, a1_ff, q3_ff, q4_ff, q5_ff;
   logic signed [63:0] p_ff, vt_ff, at_ff;
   logic [63:0] dm_ff;
   logic [15:0] rem_ff;
   logic        neg_ff;
   logic [3:0]  dig_ff;
   logic [2:0]  left_ff;
   logic        rsp_valid_ff;

   logic out_load, last_step, div_done;
   logic signed [63:0] dsc, w, q;
   logic [15:0] dv;
   logic [16:0] r_t;
   logic [63:0] m_t;

   function automatic logic signed [63:0] half64(input logic signed [63:0] x);
      logic signed [63:0] t;
      t = x + $signed({63'b0, x[63]});
      return t >>> 1;
   endfunction

   function automatic logic signed [63:0] mul_sat(input logic signed [63:0] a,
                                                  input logic [15:0] k);
      logic signed [80:0] pr;
      pr = 81'(a) * $signed({1'b0, k});
      if (pr > 81'(SAT)) return SAT;
      else if (pr < -81'(SAT)) return -SAT;
      else return pr[63:0];
   endfunction

   // Round to nearest (ties away) by 2^GUARD_BITS, then clamp to 32 bits.
   function automatic logic [31:0] out32(input logic signed [63:0] x);
      logic [64:0] mag;
      logic [44:0] r;
      logic [31:0] v;
      mag = x[63] ? (65'd0 - {x[63], x}) : {1'b0, x};
      r = 45'((mag + 65'(1 << (mjt_pkg::GUARD_BITS - 1))) >> mjt_pkg::GUARD_BITS);
      if (x[63]) v = (r > 45'h8000_0000) ? 32'h8000_0000 : (32'd0 - r[31:0]);
      else       v = (r > 45'h7FFF_FFFF) ? 32'h7FFF_FFFF : r[31:0];
      return v;
   endfunction

   assign dsc       = {{11{job_ff.dpos[32]}}, job_ff.dpos, 20'b0};
   assign last_step = (step_ff == mjt_pkg::STEP_Q5C);
   assign div_done  = (dig_ff == 4'hF) && (left_ff == 3'd1);
   assign dv        = mjt_pkg::step_by_rate(step_ff) ? job_ff.rate : job_ff.ticks;
   assign q         = neg_ff ? -$signed(dm_ff) : $signed(dm_ff);

   // Dividend for the current step.
   always_comb begin
      case (step_ff)
         mjt_pkg::STEP_V0:  w = {{12{job_ff.vel[31]}}, job_ff.vel, 20'b0};
         mjt_pkg::STEP_V1:  w = {{12{job_ff.goal_vel[31]}}, job_ff.goal_vel, 20'b0};
         mjt_pkg::STEP_A0:  w = {{12{job_ff.acc[31]}}, job_ff.acc, 20'b0};
         mjt_pkg::STEP_A1:  w = {{12{job_ff.goal_acc[31]}}, job_ff.goal_acc, 20'b0};
         mjt_pkg::STEP_Q3A: w = dsc * 64'sd10;
         mjt_pkg::STEP_Q3B: w = v0_ff * 64'sd6 + v1_ff * 64'sd4;
         mjt_pkg::STEP_Q3C: w = half64(a1_ff - a0_ff * 64'sd3);
         mjt_pkg::STEP_Q4A: w = dsc * 64'sd15;
         mjt_pkg::STEP_Q4B: w = v0_ff * 64'sd8 + v1_ff * 64'sd7;
         mjt_pkg::STEP_Q4C: w = half64(a0_ff * 64'sd3 - a1_ff * 64'sd2);
         mjt_pkg::STEP_Q5A: w = dsc * 64'sd6;
         mjt_pkg::STEP_Q5B: w = (v0_ff + v1_ff) * 64'sd3;
         mjt_pkg::STEP_Q5C: w = half64(a1_ff - a0_ff);
         default:           w = '0;
      endcase
   end

   // Four restoring quotient bits per cycle.
   always_comb begin
      r_t = {1'b0, rem_ff};
      m_t = dm_ff;
      for (int i = 0; i < 4; i++) begin
         r_t = {r_t[15:0], m_t[63]};
         m_t = {m_t[62:0], 1'b0};
         if (r_t >= {1'b0, dv}) begin
            r_t = r_t - {1'b0, dv};
            m_t[0] = 1'b1;
         end
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mjt_pkg::ST_IDLE: if (job_valid) state_in = job.ok ? mjt_pkg::ST_LOAD
                                                           : mjt_pkg::ST_OUT;
         mjt_pkg::ST_LOAD: state_in = mjt_pkg::ST_DIV;
         mjt_pkg::ST_DIV:  if (div_done) state_in = mjt_pkg::ST_ACC;
         mjt_pkg::ST_ACC:  state_in = last_step ? mjt_pkg::ST_SUM : mjt_pkg::ST_LOAD;
         mjt_pkg::ST_SUM:  state_in = mjt_pkg::ST_MUL1;
         mjt_pkg::ST_MUL1: state_in = mjt_pkg::ST_MUL2;
         mjt_pkg::ST_MUL2: state_in = mjt_pkg::ST_OUT;
         mjt_pkg::ST_OUT:  if (out_load) state_in = mjt_pkg::ST_IDLE;
         default:          state_in = mjt_pkg::ST_IDLE;
      endcase
   end

   // Outputs of the sequencer.
   always_comb begin
      job_pop  = (state_ff == mjt_pkg::ST_IDLE) && job_valid;
      out_load = (state_ff == mjt_pkg::ST_OUT) && (!rsp_valid_ff || !rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mjt_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_load) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         mjt_pkg::ST_IDLE: begin
            job_ff  <= job;
            step_ff <= mjt_pkg::STEP_V0;
         end
         mjt_pkg::ST_LOAD: begin
            neg_ff  <= w[63];
            dm_ff   <= w[63] ? 64'(-w) : 64'(w);
            rem_ff  <= '0;
            dig_ff  <= '0;
            left_ff <= mjt_pkg::step_count(step_ff);
         end
         mjt_pkg::ST_DIV: begin
            dm_ff  <= m_t;
            dig_ff <= dig_ff + 1'b1;
            if (dig_ff == 4'hF) begin
               rem_ff  <= '0;
               left_ff <= left_ff - 1'b1;
            end else begin
               rem_ff <= r_t[15:0];
            end
         end
         mjt_pkg::ST_ACC: begin
            case (step_ff)
               mjt_pkg::STEP_V0:  v0_ff <= q;
               mjt_pkg::STEP_V1:  v1_ff <= q;
               mjt_pkg::STEP_A0:  a0_ff <= q;
               mjt_pkg::STEP_A1:  a1_ff <= q;
               mjt_pkg::STEP_Q3A: q3_ff <= q;
               mjt_pkg::STEP_Q3B: q3_ff <= q3_ff - q;
               mjt_pkg::STEP_Q3C: q3_ff <= q3_ff + q;
               mjt_pkg::STEP_Q4A: q4_ff <= -q;
               mjt_pkg::STEP_Q4B: q4_ff <= q4_ff + q;
               mjt_pkg::STEP_Q4C: q4_ff <= q4_ff + q;
               mjt_pkg::STEP_Q5A: q5_ff <= q;
               mjt_pkg::STEP_Q5B: q5_ff <= q5_ff - q;
               mjt_pkg::STEP_Q5C: q5_ff <= q5_ff + q;
               default:           q5_ff <= q5_ff;
            endcase
            if (!last_step) step_ff <= mjt_pkg::step_type'(step_ff + 1'b1);
         end
         mjt_pkg::ST_SUM: begin
            p_ff  <= {{12{job_ff.pos[31]}}, job_ff.pos, 20'b0} + v0_ff + half64(a0_ff)
                     + q3_ff + q4_ff + q5_ff;
            vt_ff <= v0_ff + a0_ff + q3_ff * 64'sd3 + q4_ff * 64'sd4 + q5_ff * 64'sd5;
            at_ff <= a0_ff + q3_ff * 64'sd6 + q4_ff * 64'sd12 + q5_ff * 64'sd20;
         end
         mjt_pkg::ST_MUL1: begin
            vt_ff <= mul_sat(vt_ff, job_ff.rate);
            at_ff <= mul_sat(at_ff, job_ff.rate);
         end
         mjt_pkg::ST_MUL2: at_ff <= mul_sat(at_ff, job_ff.rate);
         default: begin
            if (out_load) begin
               rsp_step_ok  <= job_ff.ok;
               rsp_last_out <= job_ff.last;
               if (job_ff.ok) begin
                  rsp_next_pos <= out32(p_ff);
                  rsp_next_vel <= out32(vt_ff);
                  rsp_next_acc <= out32(at_ff);
               end else begin
                  rsp_next_pos <= job_ff.pos;
                  rsp_next_vel <= job_ff.vel;
                  rsp_next_acc <= job_ff.acc;
               end
            end
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_bypass_skips_fit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mjt_pkg::ST_LOAD) |-> job_ff.ok)
      else $error("bypass job entered the fit sequence");
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mjt_pkg::ST_DIV) |-> (rem_ff < dv) && (left_ff != 3'd0))
      else $error("divider remainder or count out of range");
   a_out_after_accept: assert property (@(posedge clock) disable iff (reset)
      out_load |=> rsp_valid_ff && (state_ff == mjt_pkg::ST_IDLE))
      else $error("output load did not publish a transaction");
`endif

endmodule

`default_nettype wire
